// File: rtl/core/can_bit_timing_calculator_assert.svh
// assertion macros for the can bit timing calculator
// expects clk and rst_n in the scope where the macros are used
`ifndef CAN_BIT_TIMING_CALCULATOR_ASSERT_SVH
`define CAN_BIT_TIMING_CALCULATOR_ASSERT_SVH

// same-cycle implication
`define CBTC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBTC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cbtc_pkg.sv
// package for the can bit timing calculator: sequencer states, divider
// command and status structs, fixed constants; no dependencies
`default_nettype none

package cbtc_pkg;

    localparam int DividendWidth = 26;
    localparam int DivisorWidth  = 20;
    localparam int StepWidth     = 5;

    localparam logic [StepWidth-1:0] QuotSteps = 5'd26;
    localparam logic [StepWidth-1:0] Ph2Steps  = 5'd14;

    localparam logic [3:0] MaxHalvings = 4'd8;
    localparam logic [3:0] PropStart   = 4'd8;
    localparam logic [6:0] SpMax       = 7'd100;
    localparam logic [19:0] PctDivisor = 20'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_HALVE,
        ST_MUL,
        ST_DIV2,
        ST_SEARCH,
        ST_PACK
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [StepWidth-1:0] steps;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// File: rtl/core/cbtc_divider.sv
// restoring serial divider, one quotient bit per cycle, shared by the
// clock quotient and the sample point division; uses cbtc_pkg
`default_nettype none

module cbtc_divider (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire cbtc_pkg::div_cmd_t                cmd,
    input  wire logic [cbtc_pkg::DividendWidth-1:0] dividend,
    input  wire logic [cbtc_pkg::DivisorWidth-1:0]  divisor,
    output cbtc_pkg::div_status_t                  status,
    output logic [cbtc_pkg::DividendWidth-1:0]     quotient
);

    logic [cbtc_pkg::DivisorWidth-1:0]  rem_reg, rem_next;
    logic [cbtc_pkg::DivisorWidth-1:0]  dsr_reg, dsr_next;
    logic [cbtc_pkg::DividendWidth-1:0] quo_reg, quo_next;
    logic [cbtc_pkg::StepWidth-1:0]     cnt_reg, cnt_next;
    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [cbtc_pkg::DivisorWidth:0]    trial;
    logic [cbtc_pkg::DivisorWidth:0]    diff;
    logic                               ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[cbtc_pkg::DividendWidth-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = (trial >= {1'b0, dsr_reg});

        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (cmd.start)
        begin
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
            cnt_next  = cmd.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[cbtc_pkg::DivisorWidth-1:0]
                          : trial[cbtc_pkg::DivisorWidth-1:0];
            quo_next = {quo_reg[cbtc_pkg::DividendWidth-2:0], ge};
            cnt_next = cnt_reg - cbtc_pkg::StepWidth'(1);
            if (cnt_reg == cbtc_pkg::StepWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign status   = {busy_reg, done_reg};
    assign quotient = quo_reg;

`include "can_bit_timing_calculator_assert.svh"

    `CBTC_ASSERT_IMP(a_busy_has_steps, busy_reg, cnt_reg != '0, "divider busy with no steps left")
    `CBTC_ASSERT_NXT(a_done_is_pulse, done_reg, !done_reg, "divider done held longer than a cycle")
    `CBTC_ASSERT_IMP(a_start_when_free, cmd.start, !busy_reg, "divider started while busy")

endmodule

`default_nettype wire

// File: rtl/core/can_bit_timing_calculator.sv
// can bit timing calculator top level: sequencer around the shared serial
// divider; uses cbtc_pkg, cbtc_divider and the assertion macro header
//
//  channel | signals                                          | dir
//  in      | in_valid in_ready osc_clock_hz bit_rate          | sink
//          | sample_point_pct jump_width                      |
//  out     | out_valid out_ready cnf1_byte cnf2_byte          | source
//          | cnf3_byte exact                                  |
//
// one transaction runs from accept to result through 26 divider
// steps for the clock quotient, up to 8 halvings, one multiply, 14 divider
// steps for phase 2, up to 8 propagation trials and a packing step
// the serial divider does the bulk of that work; in_ready is high only
// while the sequencer is idle
// a waiting result is held in the output register while the next transaction
// is worked on; packing waits until that register is free
// reset clears the sequencer and output valid; no clearing pass is needed
`default_nettype none

module can_bit_timing_calculator #(
    parameter int MAX_QUANTA = 25,
    parameter int MIN_QUANTA = 5
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [25:0] osc_clock_hz,
    input  wire logic [19:0] bit_rate,
    input  wire logic [6:0]  sample_point_pct,
    input  wire logic [2:0]  jump_width,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       cnf1_byte,
    output logic [7:0]       cnf2_byte,
    output logic [7:0]       cnf3_byte,
    output logic             exact
);

    cbtc_pkg::state_t state_reg, state_next;

    cbtc_pkg::div_cmd_t                div_cmd;
    cbtc_pkg::div_status_t             div_status;
    logic [cbtc_pkg::DividendWidth-1:0] div_dividend;
    logic [cbtc_pkg::DivisorWidth-1:0]  div_divisor;
    logic [cbtc_pkg::DividendWidth-1:0] div_quotient;

    logic [2:0]  sjw_reg, sjw_next;
    logic [6:0]  span_reg, span_next;
    logic        sat_reg, sat_next;
    logic [7:0]  q_reg, q_next;
    logic [6:0]  tbit_reg, tbit_next;
    logic [8:0]  brp_reg, brp_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [6:0]  ph2_reg, ph2_next;
    logic [3:0]  prop_reg, prop_next;
    logic [6:0]  ph1_reg, ph1_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  cnf1_reg, cnf1_next;
    logic [7:0]  cnf2_reg, cnf2_next;
    logic [7:0]  cnf3_reg, cnf3_next;
    logic        exact_reg, exact_next;

    logic [6:0]  sp_clamped;
    logic        quot_sat;
    logic        in_range;
    logic        halve_stop;
    logic [13:0] ph2_product;
    logic [9:0]  lhs1, rhs1, lhs2;
    logic        prop_fits;
    logic [7:0]  ph1_calc;
    logic        out_free;
    logic [8:0]  brp_m1, seg_sum;
    logic [7:0]  ph1_m1, prop_m1, ph2_m1;
    logic [2:0]  sjw_m1;
    logic [17:0] exact_product;

    cbtc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    always_comb
    begin
        sp_clamped  = (sample_point_pct > cbtc_pkg::SpMax) ? cbtc_pkg::SpMax : sample_point_pct;
        quot_sat    = |div_quotient[cbtc_pkg::DividendWidth-1:8];
        in_range    = (tbit_reg > 7'(MIN_QUANTA)) && (tbit_reg < 7'(MAX_QUANTA));
        halve_stop  = in_range || (cnt_reg == cbtc_pkg::MaxHalvings);
        ph2_product = 14'(tbit_reg) * 14'(span_reg);
        lhs1        = 10'd1 + 10'(prop_reg) + 10'(ph2_reg) + 10'(ph2_reg) + 10'(ph2_reg);
        rhs1        = 10'(tbit_reg) + 10'd8;
        lhs2        = 10'd1 + 10'(prop_reg) + 10'(ph2_reg) + 10'(ph2_reg);
        prop_fits   = (lhs1 <= rhs1) && (10'(tbit_reg) >= lhs2);
        ph1_calc    = 8'(tbit_reg) - 8'd1 - 8'(prop_reg) - 8'(ph2_reg);
        out_free    = !out_valid_reg || out_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cbtc_pkg::ST_IDLE:
                if (in_valid)
                    state_next = cbtc_pkg::ST_DIV1;
            cbtc_pkg::ST_DIV1:
                if (div_status.done)
                    state_next = cbtc_pkg::ST_HALVE;
            cbtc_pkg::ST_HALVE:
                if (halve_stop)
                    state_next = cbtc_pkg::ST_MUL;
            cbtc_pkg::ST_MUL:
                state_next = cbtc_pkg::ST_DIV2;
            cbtc_pkg::ST_DIV2:
                if (div_status.done)
                    state_next = cbtc_pkg::ST_SEARCH;
            cbtc_pkg::ST_SEARCH:
                if (prop_fits || prop_reg == 4'd1)
                    state_next = cbtc_pkg::ST_PACK;
            cbtc_pkg::ST_PACK:
                if (out_free)
                    state_next = cbtc_pkg::ST_IDLE;
            default:
                state_next = cbtc_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready      = 1'b0;
        div_cmd.start = 1'b0;
        div_cmd.steps = cbtc_pkg::QuotSteps;
        div_dividend  = osc_clock_hz;
        div_divisor   = bit_rate;
        unique case (state_reg)
            cbtc_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                div_cmd.start = in_valid;
            end
            cbtc_pkg::ST_MUL:
            begin
                div_cmd.start = 1'b1;
                div_cmd.steps = cbtc_pkg::Ph2Steps;
                div_dividend  = {ph2_product, 12'd0};
                div_divisor   = cbtc_pkg::PctDivisor;
            end
            default:
            begin
                in_ready      = 1'b0;
                div_cmd.start = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        sjw_next       = sjw_reg;
        span_next      = span_reg;
        sat_next       = sat_reg;
        q_next         = q_reg;
        tbit_next      = tbit_reg;
        brp_next       = brp_reg;
        cnt_next       = cnt_reg;
        ph2_next       = ph2_reg;
        prop_next      = prop_reg;
        ph1_next       = ph1_reg;
        cnf1_next      = cnf1_reg;
        cnf2_next      = cnf2_reg;
        cnf3_next      = cnf3_reg;
        exact_next     = exact_reg;
        out_valid_next = out_valid_reg && !out_ready;

        brp_m1        = brp_reg - 9'd1;
        ph1_m1        = 8'(ph1_reg) - 8'd1;
        prop_m1       = 8'(prop_reg) - 8'd1;
        ph2_m1        = 8'(ph2_reg) - 8'd1;
        sjw_m1        = sjw_reg - 3'd1;
        seg_sum       = 9'(prop_reg) + 9'(ph1_reg) + 9'(ph2_reg) + 9'd1;
        exact_product = 18'(brp_reg) * 18'(seg_sum);

        case (state_reg)
            cbtc_pkg::ST_IDLE:
                if (in_valid)
                begin
                    sjw_next  = jump_width;
                    span_next = cbtc_pkg::SpMax - sp_clamped;
                end
            cbtc_pkg::ST_DIV1:
                if (div_status.done)
                begin
                    sat_next  = quot_sat;
                    q_next    = quot_sat ? 8'hFF : div_quotient[7:0];
                    tbit_next = quot_sat ? 7'h7F : div_quotient[7:1];
                    brp_next  = 9'd1;
                    cnt_next  = '0;
                end
            cbtc_pkg::ST_HALVE:
                if (!halve_stop)
                begin
                    tbit_next = tbit_reg >> 1;
                    brp_next  = brp_reg << 1;
                    cnt_next  = cnt_reg + 4'd1;
                end
            cbtc_pkg::ST_DIV2:
                if (div_status.done)
                begin
                    ph2_next  = div_quotient[6:0];
                    prop_next = cbtc_pkg::PropStart;
                end
            cbtc_pkg::ST_SEARCH:
                if (prop_fits)
                    ph1_next = ph1_calc[6:0];
                else if (prop_reg == 4'd1)
                begin
                    prop_next = '0;
                    ph1_next  = '0;
                end
                else
                    prop_next = prop_reg - 4'd1;
            cbtc_pkg::ST_PACK:
                if (out_free)
                begin
                    cnf1_next      = {sjw_m1[1:0], brp_m1[5:0]};
                    cnf2_next      = {1'b1, 1'b0, ph1_m1[2:0], prop_m1[2:0]};
                    cnf3_next      = {5'd0, ph2_m1[2:0]};
                    exact_next     = !sat_reg && (exact_product == 18'(q_reg));
                    out_valid_next = 1'b1;
                end
            default:
                out_valid_next = out_valid_reg && !out_ready;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbtc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sjw_reg   <= sjw_next;
        span_reg  <= span_next;
        sat_reg   <= sat_next;
        q_reg     <= q_next;
        tbit_reg  <= tbit_next;
        brp_reg   <= brp_next;
        cnt_reg   <= cnt_next;
        ph2_reg   <= ph2_next;
        prop_reg  <= prop_next;
        ph1_reg   <= ph1_next;
        cnf1_reg  <= cnf1_next;
        cnf2_reg  <= cnf2_next;
        cnf3_reg  <= cnf3_next;
        exact_reg <= exact_next;
    end

    assign out_valid = out_valid_reg;
    assign cnf1_byte = cnf1_reg;
    assign cnf2_byte = cnf2_reg;
    assign cnf3_byte = cnf3_reg;
    assign exact     = exact_reg;

`include "can_bit_timing_calculator_assert.svh"

    `CBTC_ASSERT_NXT(a_accept_starts_div, in_valid && in_ready, div_status.busy, "accepted transaction did not start the divider")
    `CBTC_ASSERT_IMP(a_busy_in_div_state, div_status.busy, state_reg == cbtc_pkg::ST_DIV1 || state_reg == cbtc_pkg::ST_DIV2, "divider busy outside a divide state")
    `CBTC_ASSERT_IMP(a_result_from_pack, $rose(out_valid_reg), $past(state_reg) == cbtc_pkg::ST_PACK, "result raised outside packing")

endmodule

`default_nettype wire

// File: sim/testbench.sv
// self-checking testbench for can_bit_timing_calculator: queue-fed driver, clocked
// monitor and an in-bench model of the segment search and register packing
// depends only on the rtl top level can_bit_timing_calculator

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_QUANTA   = 25;
    localparam int MIN_QUANTA   = 5;
    localparam int HALVING_CAP  = 8;
    localparam int PROP_TOP     = 8;
    localparam int PCT_FULL     = 100;
    localparam int QUOT_CAP     = 255;
    localparam int RANDOM_REQS  = 530;
    localparam int PHASE_B_AT   = 200;
    localparam int PHASE_C_AT   = 400;
    localparam int HOLD_AT      = 420;
    localparam int HOLD_CYCLES  = 500;
    localparam int SETTLE       = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [25:0] osc;
        logic [19:0] rate;
        logic [6:0]  sp;
        logic [2:0]  sjw;
        logic        drain;
    } request_t;

    typedef struct packed {
        logic [7:0] cnf1;
        logic [7:0] cnf2;
        logic [7:0] cnf3;
        logic       exact;
    } timing_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [25:0] osc_clock_hz = '0;
    logic [19:0] bit_rate = '0;
    logic [6:0]  sample_point_pct = '0;
    logic [2:0]  jump_width = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  cnf1_byte;
    logic [7:0]  cnf2_byte;
    logic [7:0]  cnf3_byte;
    logic        exact;

    request_t request_q[$];
    timing_t  timing_q[$];

    int  in_count = 0;
    int  out_count = 0;
    int  total_reqs = 0;
    int  fail_cnt = 0;
    int  exact_cnt = 0;
    int  cycle_cnt = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  in_took = 1'b0;

    int unsigned std_rates[9] = '{10000, 20000, 50000, 100000, 125000,
                                  250000, 500000, 800000, 1000000};
    int unsigned std_oscs[7]  = '{4000000, 8000000, 10000000, 16000000,
                                  20000000, 24000000, 40000000};

    can_bit_timing_calculator #(
        .MAX_QUANTA(MAX_QUANTA),
        .MIN_QUANTA(MIN_QUANTA)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .osc_clock_hz     (osc_clock_hz),
        .bit_rate         (bit_rate),
        .sample_point_pct (sample_point_pct),
        .jump_width       (jump_width),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .cnf1_byte        (cnf1_byte),
        .cnf2_byte        (cnf2_byte),
        .cnf3_byte        (cnf3_byte),
        .exact            (exact)
    );

    always #1 clk = ~clk;

    function automatic timing_t calc_bit_timing(logic [25:0] osc, logic [19:0] rate,
                                                logic [6:0] sp, logic [2:0] sjw);
        timing_t r;
        longint  quot;
        bit      sat;
        int      q;
        int      tbit;
        int      brp;
        int      pct;
        int      ph2;
        int      ph1;
        int      prop_seg;
        int      brp_m;
        int      ph1_m;
        int      prop_m;
        int      ph2_m;
        logic [1:0] sjw_m;
        quot = 0;
        if (rate == '0)
            sat = 1'b1;
        else
        begin
            quot = longint'(osc) / longint'(rate);
            sat = quot > QUOT_CAP;
        end
        q = sat ? QUOT_CAP : int'(quot);
        tbit = q / 2;
        brp = 1;
        for (int i = 0; i < HALVING_CAP; i++)
        begin
            if (tbit > MIN_QUANTA && tbit < MAX_QUANTA)
                break;
            tbit = tbit / 2;
            brp = brp * 2;
        end
        pct = (sp > PCT_FULL) ? PCT_FULL : int'(sp);
        ph2 = (tbit * (PCT_FULL - pct)) / PCT_FULL;
        prop_seg = 0;
        ph1 = 0;
        for (int p = PROP_TOP; p > 0; p--)
        begin
            if ((1 + p + 2 * ph2) <= (tbit + 8 - ph2) && (tbit - 1 - p - ph2) >= ph2)
            begin
                prop_seg = p;
                ph1 = tbit - 1 - p - ph2;
                break;
            end
        end
        sjw_m  = sjw[1:0] - 2'd1;
        brp_m  = brp - 1;
        ph1_m  = ph1 - 1;
        prop_m = prop_seg - 1;
        ph2_m  = ph2 - 1;
        r.cnf1  = {sjw_m, brp_m[5:0]};
        r.cnf2  = {2'b10, ph1_m[2:0], prop_m[2:0]};
        r.cnf3  = {5'b0, ph2_m[2:0]};
        r.exact = !sat && (q == brp * (prop_seg + ph1 + ph2 + 1));
        return r;
    endfunction

    function automatic int idle_share(bit sender_side);
        if (in_count < PHASE_B_AT)
            return sender_side ? 10 : 88;
        if (in_count < PHASE_C_AT)
            return sender_side ? 88 : 10;
        return 0;
    endfunction

    task automatic add_request(longint osc, longint rate, int sp, int sjw, bit drain);
        request_t r;
        r.osc   = osc[25:0];
        r.rate  = rate[19:0];
        r.sp    = sp[6:0];
        r.sjw   = sjw[2:0];
        r.drain = drain;
        request_q.push_back(r);
        total_reqs++;
    endtask

    // accepted input transactions
    always @(posedge clk)
    begin
        in_took <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            timing_q.push_back(calc_bit_timing(osc_clock_hz, bit_rate,
                                               sample_point_pct, jump_width));
            in_count++;
        end
    end

    always @(negedge clk)
    begin : drive_requests
        request_t cur;
        if (rst_n && (!in_valid || in_took))
        begin
            if (request_q.size() > 0 && $urandom_range(99) >= idle_share(1'b1)
                && !(request_q[0].drain && out_count != in_count))
            begin
                cur = request_q.pop_front();
                osc_clock_hz     <= cur.osc;
                bit_rate         <= cur.rate;
                sample_point_pct <= cur.sp;
                jump_width       <= cur.sjw;
                in_valid         <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (in_count == HOLD_AT && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(negedge clk)
        out_ready <= rst_n && hold_left == 0 && $urandom_range(99) >= idle_share(1'b0);

    always @(posedge clk)
    begin : check_settings
        timing_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (timing_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= REPORT_LIMIT)
                    $display("unexpected result: cnf1 %h cnf2 %h cnf3 %h exact %b",
                             cnf1_byte, cnf2_byte, cnf3_byte, exact);
            end
            else
            begin
                want = timing_q.pop_front();
                out_count++;
                if (want.exact)
                    exact_cnt++;
                if (want != {cnf1_byte, cnf2_byte, cnf3_byte, exact})
                begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_LIMIT)
                        $display("mismatch on transaction %0d: expected cnf1 %h cnf2 %h %s",
                                 out_count, want.cnf1, want.cnf2,
                                 $sformatf("cnf3 %h exact %b, got %h %h %h %b",
                                           want.cnf3, want.exact, cnf1_byte,
                                           cnf2_byte, cnf3_byte, exact));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("can_bit_timing_calculator verification failed");
            $finish;
        end
    end

    initial
    begin
        longint osc;
        longint rate;
        int     kind;
        int     sp;
        int     sjw;
        bit     drain;

        // extremes and typical set-ups
        add_request(1, 1, 0, 1, 1'b0);
        add_request(26'h3FFFFFF, 20'hFFFFF, 127, 7, 1'b0);
        add_request(16000000, 500000, 75, 1, 1'b0);
        add_request(8000000, 125000, 87, 2, 1'b0);
        add_request(20000000, 250000, 80, 3, 1'b0);
        add_request(40000000, 1000000, 70, 4, 1'b0);
        // zero bit rate and saturated quotients
        add_request(16000000, 0, 75, 1, 1'b0);
        add_request(40000000, 1000, 60, 2, 1'b0);
        add_request(256, 1, 50, 1, 1'b0);
        add_request(255, 1, 50, 1, 1'b0);
        // bit time never in range
        add_request(8, 1, 50, 1, 1'b0);
        add_request(3, 1, 50, 1, 1'b0);
        // bit time at the limits
        add_request(10, 1, 50, 1, 1'b0);
        add_request(12, 1, 50, 1, 1'b0);
        add_request(48, 1, 50, 1, 1'b0);
        add_request(50, 1, 50, 1, 1'b0);
        // sample point beyond 100 and segment overflow
        add_request(48, 1, 100, 2, 1'b0);
        add_request(48, 1, 101, 3, 1'b0);
        add_request(20000000, 500000, 127, 4, 1'b0);
        // no propagation fits
        add_request(16000000, 500000, 0, 1, 1'b0);
        add_request(30, 1, 10, 1, 1'b0);
        // zero and wide jump width
        add_request(16000000, 500000, 75, 0, 1'b0);
        add_request(16000000, 500000, 75, 5, 1'b0);
        add_request(16000000, 500000, 75, 6, 1'b0);

        for (int k = 0; k < RANDOM_REQS; k++)
        begin
            kind  = $urandom_range(99);
            drain = (k == PHASE_B_AT - 20) || (k == PHASE_C_AT - 20);
            sp    = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(90, 50);
            sjw   = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
            if (kind < 45)
            begin
                rate = std_rates[$urandom_range(8)];
                osc  = std_oscs[$urandom_range(6)];
            end
            else if (kind < 80)
            begin
                rate = $urandom_range(1000000, 1);
                osc  = rate * $urandom_range(255, 2);
                if ($urandom_range(3) == 0)
                    osc = osc + $urandom_range(int'(rate) - 1, 0);
                if (osc > 26'h3FFFFFF)
                    osc = 26'h3FFFFFF;
            end
            else
            begin
                rate = $urandom & 20'hFFFFF;
                osc  = $urandom & 26'h3FFFFFF;
                if (kind >= 95)
                    rate = rate & 20'h000FF;
                sp   = $urandom_range(127);
                sjw  = $urandom_range(7);
            end
            add_request(osc, rate, sp, sjw, drain);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (in_count == total_reqs && out_count == in_count);
        repeat (SETTLE) @(posedge clk);
        if (timing_q.size() != 0)
            fail_cnt++;
        $display("%0d requests checked, %0d with an exact quotient, over three idling phases",
                 out_count, exact_cnt);
        $display("including a long output hold-off and %0d mismatches", fail_cnt);
        if (fail_cnt == 0)
            $display("can_bit_timing_calculator verification clean");
        else
            $display("can_bit_timing_calculator verification failed");
        $finish;
    end

endmodule
